@@ rtl/mer_pkg.sv @@
// Shared types, widths and codes for the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 10;
  localparam int OUT_W       = COORD_BITS + 1;
  localparam int OFS_W       = RADIUS_BITS + 2;
  localparam int SQ_W        = 2 * RADIUS_BITS;
  localparam int MUL_W       = RADIUS_BITS + SQ_W;
  // Decision value: a cubic product of the radius plus headroom for the step terms.
  localparam int DEC_W       = 3 * RADIUS_BITS + 10;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int RES_DEPTH   = 2;
  localparam int RPTR_W      = 1;
  localparam int RCNT_W      = 2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LD_RX2,
    PH_LD_RY2,
    PH_LD_M1,
    PH_LD_M2,
    PH_R1_FIRST,
    PH_R1_WALK,
    PH_R2_FIRST,
    PH_R2_WALK
  } phase_t;

  typedef struct packed {
    logic                          is_load;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0] radius_x;
    logic        [RADIUS_BITS-1:0] radius_y;
  } cmd_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] left_x;
    logic signed [OUT_W-1:0] lower_y;
    logic signed [OUT_W-1:0] upper_y;
    logic                    in_second_region;
    logic                    last_point;
  } res_t;

  typedef struct packed {
    logic res_push;
    logic loading;
  } back_status_t;

endpackage

@@ rtl/mer_front.sv @@
// Front end: accepts requests, classifies them and queues them for the walker.
module mer_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   action,
  input  logic signed [mer_pkg::COORD_BITS-1:0]  center_x,
  input  logic signed [mer_pkg::COORD_BITS-1:0]  center_y,
  input  logic        [mer_pkg::RADIUS_BITS-1:0] radius_x,
  input  logic        [mer_pkg::RADIUS_BITS-1:0] radius_y,
  input  logic                                   cmd_pop,
  output logic                                   cmd_empty,
  output mer_pkg::cmd_t                          cmd
);

  mer_pkg::cmd_t                   queue [mer_pkg::QUEUE_DEPTH];
  mer_pkg::cmd_t                   cmd_in;
  logic [mer_pkg::QPTR_W-1:0]      wr_ptr;
  logic [mer_pkg::QPTR_W-1:0]      rd_ptr;
  logic [mer_pkg::QCNT_W-1:0]      count;
  logic                            wr_en;
  logic                            rd_en;

  // A zero radius is taken as one so that the walk always terminates.
  always_comb begin
    cmd_in.is_load  = (action == mer_pkg::ACT_LOAD);
    cmd_in.center_x = center_x;
    cmd_in.center_y = center_y;
    cmd_in.radius_x = (radius_x == '0) ? mer_pkg::RADIUS_BITS'(1) : radius_x;
    cmd_in.radius_y = (radius_y == '0) ? mer_pkg::RADIUS_BITS'(1) : radius_y;
  end

  assign full      = (count == mer_pkg::QCNT_W'(mer_pkg::QUEUE_DEPTH));
  assign cmd_empty = (count == '0);
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && !cmd_empty;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + mer_pkg::QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + mer_pkg::QPTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + mer_pkg::QCNT_W'(1);
        2'b01:   count <= count - mer_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/mer_back.sv @@
// Back end: squares the radii, walks both regions and queues the points.
module mer_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_empty,
  input  mer_pkg::cmd_t         cmd,
  output logic                  cmd_pop,
  output logic                  empty,
  input  logic                  pop,
  output mer_pkg::res_t         res,
  output mer_pkg::back_status_t status
);

  mer_pkg::phase_t phase, phase_next;

  logic signed [mer_pkg::COORD_BITS-1:0]  cx, cx_next, cy, cy_next;
  logic        [mer_pkg::RADIUS_BITS-1:0] rx, rx_next, ry, ry_next;
  logic        [mer_pkg::SQ_W-1:0]        rx2, rx2_next, ry2, ry2_next;
  logic signed [mer_pkg::OFS_W-1:0]       ofs_x, ofs_x_next, ofs_y, ofs_y_next;
  logic signed [mer_pkg::DEC_W-1:0]       acc_a, acc_a_next, acc_b, acc_b_next;
  logic signed [mer_pkg::DEC_W-1:0]       dec, dec_next, m2, m2_next;
  logic signed [mer_pkg::DEC_W-1:0]       k5_rx2, k5_rx2_next, k4_rx2, k4_rx2_next;
  logic signed [mer_pkg::DEC_W-1:0]       k5_ry2, k5_ry2_next, k4_ry2, k4_ry2_next;
  logic signed [mer_pkg::DEC_W-1:0]       rx2_s, ry2_s;

  // Region walk terms; acc_a tracks ry2*x and acc_b tracks rx2*y.
  logic                                   r1_step_y, r1_done;
  logic signed [mer_pkg::DEC_W-1:0]       r1_a, r1_b, r1_dec;
  logic                                   r2_step_x, r2_done;
  logic signed [mer_pkg::DEC_W-1:0]       r2_a, r2_b, r2_dec;

  logic [mer_pkg::RADIUS_BITS-1:0] mul_a;
  logic [mer_pkg::SQ_W-1:0]        mul_b;
  logic [mer_pkg::MUL_W-1:0]       mul_p;

  logic walking, do_load, do_step, res_push, res_pop, res_space;
  mer_pkg::res_t             res_new;
  mer_pkg::res_t             res_q [mer_pkg::RES_DEPTH];
  logic [mer_pkg::RPTR_W-1:0] res_wr, res_rd;
  logic [mer_pkg::RCNT_W-1:0] res_cnt;

  assign rx2_s = mer_pkg::DEC_W'(rx2);
  assign ry2_s = mer_pkg::DEC_W'(ry2);
  assign mul_p = mer_pkg::MUL_W'(mul_a) * mer_pkg::MUL_W'(mul_b);

  always_comb begin
    r1_step_y = (dec > 0);
    r1_a      = acc_a + ry2_s;
    r1_b      = r1_step_y ? (acc_b - rx2_s) : acc_b;
    r1_dec    = dec + (acc_a <<< 1) + k5_ry2
              + (r1_step_y ? (k4_rx2 - (acc_b <<< 1)) : '0);
    r1_done   = (r1_a > r1_b);

    r2_step_x = (dec > 0);
    r2_b      = acc_b + rx2_s;
    r2_a      = r2_step_x ? (acc_a - ry2_s) : acc_a;
    r2_dec    = dec + (acc_b <<< 1) + k5_rx2
              + (r2_step_x ? (k4_ry2 - (acc_a <<< 1)) : '0);
    r2_done   = (r2_b > r2_a);
  end

  // Next state.
  always_comb begin
    phase_next = phase;
    if (do_load) begin
      phase_next = mer_pkg::PH_LD_RX2;
    end else begin
      case (phase)
        mer_pkg::PH_LD_RX2:   phase_next = mer_pkg::PH_LD_RY2;
        mer_pkg::PH_LD_RY2:   phase_next = mer_pkg::PH_LD_M1;
        mer_pkg::PH_LD_M1:    phase_next = mer_pkg::PH_LD_M2;
        mer_pkg::PH_LD_M2:    phase_next = mer_pkg::PH_R1_FIRST;
        mer_pkg::PH_R1_FIRST: if (do_step) phase_next = mer_pkg::PH_R1_WALK;
        mer_pkg::PH_R1_WALK:  if (do_step && r1_done) phase_next = mer_pkg::PH_R2_FIRST;
        mer_pkg::PH_R2_FIRST: if (do_step) phase_next = mer_pkg::PH_R2_WALK;
        mer_pkg::PH_R2_WALK:  if (do_step && r2_done) phase_next = mer_pkg::PH_IDLE;
        default:              phase_next = phase;
      endcase
    end
  end

  // Control outputs and multiplier operand selection.
  always_comb begin
    walking   = phase inside {mer_pkg::PH_R1_FIRST, mer_pkg::PH_R1_WALK,
                              mer_pkg::PH_R2_FIRST, mer_pkg::PH_R2_WALK};
    res_space = (res_cnt != mer_pkg::RCNT_W'(mer_pkg::RES_DEPTH));
    cmd_pop   = !cmd_empty && (phase == mer_pkg::PH_IDLE || walking)
              && (cmd.is_load || phase == mer_pkg::PH_IDLE || res_space);
    do_load   = cmd_pop && cmd.is_load;
    do_step   = cmd_pop && !cmd.is_load && walking;
    res_push  = do_step;
    status.res_push = res_push;
    status.loading  = phase inside {mer_pkg::PH_LD_RX2, mer_pkg::PH_LD_RY2,
                                    mer_pkg::PH_LD_M1, mer_pkg::PH_LD_M2};
    case (phase)
      mer_pkg::PH_LD_RX2: begin
        mul_a = rx;
        mul_b = mer_pkg::SQ_W'(rx);
      end
      mer_pkg::PH_LD_RY2: begin
        mul_a = ry;
        mul_b = mer_pkg::SQ_W'(ry);
      end
      mer_pkg::PH_LD_M1: begin
        mul_a = ry;
        mul_b = rx2;
      end
      mer_pkg::PH_LD_M2: begin
        mul_a = rx;
        mul_b = ry2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Datapath.
  always_comb begin
    cx_next     = cx;
    cy_next     = cy;
    rx_next     = rx;
    ry_next     = ry;
    rx2_next    = rx2;
    ry2_next    = ry2;
    ofs_x_next  = ofs_x;
    ofs_y_next  = ofs_y;
    acc_a_next  = acc_a;
    acc_b_next  = acc_b;
    dec_next    = dec;
    m2_next     = m2;
    k5_rx2_next = k5_rx2;
    k4_rx2_next = k4_rx2;
    k5_ry2_next = k5_ry2;
    k4_ry2_next = k4_ry2;
    if (do_load) begin
      cx_next = cmd.center_x;
      cy_next = cmd.center_y;
      rx_next = cmd.radius_x;
      ry_next = cmd.radius_y;
    end else begin
      case (phase)
        mer_pkg::PH_LD_RX2: rx2_next = mul_p[mer_pkg::SQ_W-1:0];
        mer_pkg::PH_LD_RY2: ry2_next = mul_p[mer_pkg::SQ_W-1:0];
        mer_pkg::PH_LD_M1:  acc_b_next = mer_pkg::DEC_W'(mul_p);
        mer_pkg::PH_LD_M2: begin
          m2_next     = mer_pkg::DEC_W'(mul_p);
          ofs_x_next  = '0;
          ofs_y_next  = mer_pkg::OFS_W'(ry);
          acc_a_next  = '0;
          dec_next    = ry2_s - acc_b;
          k5_rx2_next = (rx2_s <<< 2) + rx2_s;
          k4_rx2_next = rx2_s <<< 2;
          k5_ry2_next = (ry2_s <<< 2) + ry2_s;
          k4_ry2_next = ry2_s <<< 2;
        end
        mer_pkg::PH_R1_WALK: begin
          if (do_step) begin
            ofs_x_next = ofs_x + mer_pkg::OFS_W'(1);
            ofs_y_next = r1_step_y ? (ofs_y - mer_pkg::OFS_W'(1)) : ofs_y;
            acc_a_next = r1_a;
            acc_b_next = r1_b;
            dec_next   = r1_dec;
          end
        end
        mer_pkg::PH_R2_FIRST: begin
          if (do_step) begin
            ofs_x_next = mer_pkg::OFS_W'(rx);
            ofs_y_next = '0;
            acc_a_next = m2;
            acc_b_next = '0;
            dec_next   = rx2_s - m2;
          end
        end
        mer_pkg::PH_R2_WALK: begin
          if (do_step) begin
            ofs_y_next = ofs_y + mer_pkg::OFS_W'(1);
            ofs_x_next = r2_step_x ? (ofs_x - mer_pkg::OFS_W'(1)) : ofs_x;
            acc_a_next = r2_a;
            acc_b_next = r2_b;
            dec_next   = r2_dec;
          end
        end
        default: ;
      endcase
    end
  end

  // The point reported is the offset pair after this step's update.
  always_comb begin
    res_new.right_x = mer_pkg::OUT_W'(cx) + mer_pkg::OUT_W'(ofs_x_next);
    res_new.left_x  = mer_pkg::OUT_W'(cx) - mer_pkg::OUT_W'(ofs_x_next);
    res_new.lower_y = mer_pkg::OUT_W'(cy) + mer_pkg::OUT_W'(ofs_y_next);
    res_new.upper_y = mer_pkg::OUT_W'(cy) - mer_pkg::OUT_W'(ofs_y_next);
    res_new.in_second_region = phase inside {mer_pkg::PH_R2_FIRST, mer_pkg::PH_R2_WALK};
    res_new.last_point       = (phase == mer_pkg::PH_R2_WALK) && r2_done;
  end

  assign empty   = (res_cnt == '0);
  assign res_pop = pop && !empty;
  assign res     = res_q[res_rd];

  always_ff @(posedge clk) begin
    cx     <= cx_next;
    cy     <= cy_next;
    rx     <= rx_next;
    ry     <= ry_next;
    rx2    <= rx2_next;
    ry2    <= ry2_next;
    ofs_x  <= ofs_x_next;
    ofs_y  <= ofs_y_next;
    acc_a  <= acc_a_next;
    acc_b  <= acc_b_next;
    dec    <= dec_next;
    m2     <= m2_next;
    k5_rx2 <= k5_rx2_next;
    k4_rx2 <= k4_rx2_next;
    k5_ry2 <= k5_ry2_next;
    k4_ry2 <= k4_ry2_next;
    if (res_push) begin
      res_q[res_wr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= mer_pkg::PH_IDLE;
      res_wr  <= '0;
      res_rd  <= '0;
      res_cnt <= '0;
    end else begin
      phase <= phase_next;
      if (res_push) begin
        res_wr <= res_wr + mer_pkg::RPTR_W'(1);
      end
      if (res_pop) begin
        res_rd <= res_rd + mer_pkg::RPTR_W'(1);
      end
      case ({res_push, res_pop})
        2'b10:   res_cnt <= res_cnt + mer_pkg::RCNT_W'(1);
        2'b01:   res_cnt <= res_cnt - mer_pkg::RCNT_W'(1);
        default: res_cnt <= res_cnt;
      endcase
    end
  end

endmodule

@@ rtl/midpoint_ellipse_rasterizer.sv @@
// Top level of the midpoint ellipse rasterizer: front queue, walker and checks.
//
// This block walks the outline of an axis-aligned ellipse with the integer
// midpoint method and hands out one point per step request, each point as
// four mirrored coordinates around the center. A load request (action low)
// latches a center and two radii, gives no point and restarts the walker; a
// radius of zero is taken as one. Each step request (action high) then gives
// one point: region 1 from the top of the ellipse while x advances, then
// region 2 from the side while y advances, and the final point of region 2
// carries last_point. Step requests while no ellipse is active give nothing.
// Requests enter a four-entry queue in the front end, so the producer keeps
// pushing while the walker is busy; points leave through a two-entry queue,
// so a stalled consumer never holds up the push side until both queues fill.
// Once loaded, the walker turns out one point per clock while step requests
// wait and the point queue has room, because every step is a handful of
// additions on running products kept in registers. A load takes the request
// and then holds the walker while its single shared multiplier forms rx*rx,
// ry*ry, ry*rx*rx and rx*ry*ry one after another. A step request accepted
// into an empty block passes through the request queue and then the point
// queue, which drives the result ports. Coordinates wrap to 13 bits.
module midpoint_ellipse_rasterizer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic                                   action,
  input  logic signed [mer_pkg::COORD_BITS-1:0]  center_x,
  input  logic signed [mer_pkg::COORD_BITS-1:0]  center_y,
  input  logic        [mer_pkg::RADIUS_BITS-1:0] radius_x,
  input  logic        [mer_pkg::RADIUS_BITS-1:0] radius_y,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [mer_pkg::OUT_W-1:0]       right_x,
  output logic signed [mer_pkg::OUT_W-1:0]       left_x,
  output logic signed [mer_pkg::OUT_W-1:0]       lower_y,
  output logic signed [mer_pkg::OUT_W-1:0]       upper_y,
  output logic                                   in_second_region,
  output logic                                   last_point
);

  logic                  cmd_pop;
  logic                  cmd_empty;
  mer_pkg::cmd_t         cmd;
  mer_pkg::res_t         res;
  mer_pkg::back_status_t status;

  // The front end classifies each request and queues it.
  mer_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius_x  (radius_x),
    .radius_y  (radius_y),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  // The back end prepares the squared radii and walks the outline.
  mer_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res),
    .status    (status)
  );

  assign right_x          = res.right_x;
  assign left_x           = res.left_x;
  assign lower_y          = res.lower_y;
  assign upper_y          = res.upper_y;
  assign in_second_region = res.in_second_region;
  assign last_point       = res.last_point;

  // The walker never takes a request from an empty queue.
  assert property (@(posedge clk) disable iff (rst) cmd_pop |-> !cmd_empty)
    else $error("walker took a request from an empty queue");

  // While the multiplier sequence runs, no request is taken.
  assert property (@(posedge clk) disable iff (rst) status.loading |-> !cmd_pop)
    else $error("request taken during radius preparation");

  // A point is only produced by a step request taken from the queue.
  assert property (@(posedge clk) disable iff (rst)
                   status.res_push |-> (cmd_pop && !cmd.is_load))
    else $error("point produced without a step request");

  // A full queue stays full until the walker takes a request.
  assert property (@(posedge clk) disable iff (rst) (full && !cmd_pop) |=> full)
    else $error("request queue lost an entry");

  // Only a region 2 point can close the ellipse.
  assert property (@(posedge clk) disable iff (rst)
                   (!empty && last_point) |-> in_second_region)
    else $error("final point flagged outside region 2");

endmodule
